### design/assert_macros.svh
// Assertion helpers shared by the RTL files.
// All checks are clocked on clk and are disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge.
`define TDM_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that a condition leads to a consequence in the next cycle.
`define TDM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/tdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile dictionary match package
// Sizes, register indexes and the pixel type shared by the tile matcher.
// ----------------------------------------------------------------------------
package tdm_pkg;

	localparam int MAX_TILES   = 64;
	localparam int TILE_SIDE   = 8;
	localparam int TILE_PIXELS = TILE_SIDE * TILE_SIDE;
	localparam int IDX_W       = $clog2(MAX_TILES);
	localparam int POS_W       = $clog2(TILE_PIXELS);
	localparam int ADDR_W      = IDX_W + POS_W;
	localparam int CNT_W       = IDX_W + 1;
	localparam int CHAN_W      = 8;

	localparam int TOL_W       = 8;
	localparam int TILES_W     = 7;
	localparam int CFG_W       = 8;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILES     = 1'd1;

	localparam logic OP_LOAD      = 1'b0;
	localparam logic OP_CANDIDATE = 1'b1;

	localparam logic [TOL_W-1:0]   TOL_RESET   = 8'd2;
	localparam logic [TILES_W-1:0] TILES_RESET = 7'd0;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

endpackage

### design/tile_dictionary_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile dictionary match
// Dictionary of 8x8 RGB tiles searched against streamed candidate tiles.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel. s_tuser is the opcode: a load request
// writes one dictionary pixel and leaves the block idle. A candidate request
// is compared against the same pixel position of every entry in use, one
// dictionary read per cycle from the read port of the tile memory; it passes
// through the run and drain states, and the report state when it reports.
// A candidate request with s_tlast high also reports on the m_ channel:
// m_tuser says whether an entry matched and m_tdata gives the lowest matching
// entry. No dictionary entry in use means no reads: the request goes
// straight back to idle, or to the report state when it reports.
// A waiting report does not block the next request: if a new report is due
// while the old one is still held by a stalled receiver, the block holds
// the new one and accepts nothing until the output register frees up.
// Reset clears the match marks to all ones, sets the tolerance to 2 and
// the entries in use to 0. The dictionary memory is not cleared; an entry
// must be loaded before it is searched. Register writes on cfg_ take
// effect at once; the user must make them only while the block is idle,
// which the block itself does not enforce.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tile_dictionary_match (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// tile_index[5:0], pixel_pos[11:6], red[19:12], green[27:20], blue[35:28]
	input  logic [tdm_pkg::IN_DATA_W-1:0]     s_tdata,
	// opcode
	input  logic                              s_tuser,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// match_index[5:0]
	output logic [tdm_pkg::OUT_DATA_W-1:0]    m_tdata,
	// match_found
	output logic                              m_tuser,
	input  logic                              cfg_wr_en,
	input  logic [tdm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tdm_pkg::CFG_W-1:0]         cfg_data
);
	import tdm_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_RUN    = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_REPORT = 2'd3;

	rgb_t              dict_mem [MAX_TILES*TILE_PIXELS];
	rgb_t              rdata_s1;
	logic              cmp_v_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic [1:0]         state_q;
	logic [TOL_W-1:0]   tol_q;
	logic [TILES_W-1:0] tiles_q;
	logic [MAX_TILES-1:0] marks_q;
	logic [CNT_W-1:0]   n_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [POS_W-1:0]   pos_q;
	rgb_t               cand_q;
	logic               last_q;
	logic               found_q;
	logic [IDX_W-1:0]   fidx_q;
	logic               out_valid_q;
	logic               out_found_q;
	logic [IDX_W-1:0]   out_idx_q;

	logic [IDX_W-1:0]   in_tile;
	logic [POS_W-1:0]   in_pos;
	rgb_t               in_rgb;
	logic               accept;
	logic [CNT_W-1:0]   n_active;
	logic               mismatch;
	logic               new_mark;
	logic               out_free;

	assign in_tile       = s_tdata[IDX_W-1:0];
	assign in_pos        = s_tdata[IDX_W+POS_W-1:IDX_W];
	assign in_rgb.red    = s_tdata[ADDR_W+CHAN_W-1:ADDR_W];
	assign in_rgb.green  = s_tdata[ADDR_W+2*CHAN_W-1:ADDR_W+CHAN_W];
	assign in_rgb.blue   = s_tdata[ADDR_W+3*CHAN_W-1:ADDR_W+2*CHAN_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign n_active = (CNT_W'(tiles_q) > CNT_W'(MAX_TILES)) ? CNT_W'(MAX_TILES)
		: CNT_W'(tiles_q);

	always_ff @(posedge clk) begin
		if (accept && s_tuser == OP_LOAD) begin
			dict_mem[{in_tile, in_pos}] <= in_rgb;
		end
		rdata_s1 <= dict_mem[{cnt_q, pos_q}];
		idx_s1   <= cnt_q;
	end

	tdm_pix_cmp u_cmp (
		.stored    (rdata_s1),
		.cand      (cand_q),
		.tolerance (tol_q),
		.mismatch  (mismatch)
	);

	assign new_mark = marks_q[idx_s1] && !mismatch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= TOL_RESET;
			tiles_q <= TILES_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TOLERANCE: tol_q <= cfg_data;
				REG_TILES:     tiles_q <= cfg_data[TILES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q  <= in_pos;
			cand_q <= in_rgb;
			last_q <= s_tlast;
			n_q    <= n_active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			marks_q     <= '1;
			cnt_q       <= '0;
			cmp_v_s1    <= 1'b0;
			found_q     <= 1'b0;
			fidx_q      <= '0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_idx_q   <= '0;
		end else begin
			cmp_v_s1 <= (state_q == ST_RUN);
			if (out_valid_q && m_tready && state_q != ST_REPORT) begin
				out_valid_q <= 1'b0;
			end
			if (cmp_v_s1) begin
				marks_q[idx_s1] <= new_mark;
				if (new_mark && !found_q) begin
					found_q <= 1'b1;
					fidx_q  <= idx_s1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser == OP_CANDIDATE) begin
						found_q <= 1'b0;
						fidx_q  <= '0;
						cnt_q   <= '0;
						if (n_active != '0) begin
							state_q <= ST_RUN;
						end else if (s_tlast) begin
							state_q <= ST_REPORT;
						end
					end
				end
				ST_RUN: begin
					if (CNT_W'(cnt_q) == n_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= last_q ? ST_REPORT : ST_IDLE;
				end
				ST_REPORT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_found_q <= found_q;
						out_idx_q   <= fidx_q;
						marks_q     <= '1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = OUT_DATA_W'(out_idx_q);

	`TDM_ASSERT(a_no_accept_mid_compare, !(s_tready && cmp_v_s1), "accept during compare")
	`TDM_ASSERT(a_cnt_in_range, state_q != ST_RUN || CNT_W'(cnt_q) < n_q, "read index too high")
	`TDM_ASSERT(a_found_in_range,
		state_q != ST_REPORT || !found_q || CNT_W'(fidx_q) < n_q, "reported entry too high")
	`TDM_ASSERT_NEXT(a_report_loads, state_q == ST_REPORT && out_free,
		out_valid_q && marks_q == '1 && state_q == ST_IDLE, "report not loaded")

endmodule

### design/tdm_pix_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile dictionary match pixel compare
// Flags a mismatch when any color channel differs by more than the tolerance.
// ----------------------------------------------------------------------------
module tdm_pix_cmp (
	input  tdm_pkg::rgb_t              stored,
	input  tdm_pkg::rgb_t              cand,
	input  logic [tdm_pkg::TOL_W-1:0]  tolerance,
	output logic                       mismatch
);
	import tdm_pkg::*;

	logic [CHAN_W-1:0] diff_r;
	logic [CHAN_W-1:0] diff_g;
	logic [CHAN_W-1:0] diff_b;

	assign diff_r = (stored.red > cand.red) ? (stored.red - cand.red)
		: (cand.red - stored.red);
	assign diff_g = (stored.green > cand.green) ? (stored.green - cand.green)
		: (cand.green - stored.green);
	assign diff_b = (stored.blue > cand.blue) ? (stored.blue - cand.blue)
		: (cand.blue - stored.blue);

	assign mismatch = (diff_r > tolerance) || (diff_g > tolerance) || (diff_b > tolerance);

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile dictionary match testbench
// Loads dictionary pixels and streams candidate tiles into the matcher, then
// checks every match report against a predictor kept inside the bench. A
// short directed run comes first, then random phases with new register
// settings and different amounts of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	import tdm_pkg::*;

	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int ITEM_TARGET   = 1350;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic             opcode;
		logic [IDX_W-1:0] tile;
		logic [POS_W-1:0] pos;
		rgb_t             pix;
		logic             last;
	} pixel_req_t;

	typedef struct {
		logic             found;
		logic [IDX_W-1:0] index;
	} match_report_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data  = '0;

	tile_dictionary_match dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pixel_req_t    pending_reqs[$];
	match_report_t reports_due[$];
	pixel_req_t    on_bus;
	idle_mode_t    idle_mode   = IDLE_NONE;
	int            err_count   = 0;
	int            cycle_count = 0;
	int            item_count  = 0;

	rgb_t                   dict_mem [MAX_TILES * TILE_PIXELS];
	logic [MAX_TILES-1:0]   marks     = '1;
	logic [TOL_W-1:0]       tol_reg   = TOL_RESET;
	logic [TILES_W-1:0]     tiles_reg = TILES_RESET;

	rgb_t                   plan_img    [MAX_TILES][TILE_PIXELS];
	logic [TILE_PIXELS-1:0] plan_loaded [MAX_TILES] = '{default: '0};

	function automatic int tiles_searched();
		return (tiles_reg > MAX_TILES) ? MAX_TILES : int'(tiles_reg);
	endfunction

	function automatic logic chan_far(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
		return ((a > b) ? a - b : b - a) > tol_reg;
	endfunction

	function automatic rgb_t rand_rgb();
		logic [23:0] v;
		v = 24'($urandom);
		return v;
	endfunction

	function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] v, input int d);
		int x;
		x = ($urandom_range(0, 1) == 0) ? int'(v) + d : int'(v) - d;
		if (x > 255)
			x = int'(v) - d;
		if (x < 0)
			x = int'(v) + d;
		if (x > 255)
			x = 255;
		return x[CHAN_W-1:0];
	endfunction

	function automatic rgb_t near_pixel(input rgb_t base, input int tol, input bit spoil);
		rgb_t p;
		p.red   = nudge(base.red, $urandom_range(0, tol));
		p.green = nudge(base.green, $urandom_range(0, tol));
		p.blue  = nudge(base.blue, $urandom_range(0, tol));
		if (spoil && tol < 255) begin
			case ($urandom_range(0, 2))
				0: p.red = nudge(base.red, tol + 1);
				1: p.green = nudge(base.green, tol + 1);
				default: p.blue = nudge(base.blue, tol + 1);
			endcase
		end
		return p;
	endfunction

	task automatic report_mismatch(input string what);
		if (err_count < 50)
			$display("cycle %0d: %s", cycle_count, what);
		err_count++;
	endtask

	// Updates the dictionary and match marks for one accepted request, and queues the expected report when it reports.
	task automatic apply_request(input pixel_req_t r);
		int            n;
		int            i;
		rgb_t          w;
		match_report_t rep;
		n = tiles_searched();
		if (r.opcode == OP_LOAD) begin
			dict_mem[int'(r.tile) * TILE_PIXELS + int'(r.pos)] = r.pix;
		end else begin
			for (i = 0; i < n; i++) begin
				w = dict_mem[i * TILE_PIXELS + int'(r.pos)];
				if (chan_far(w.red, r.pix.red) || chan_far(w.green, r.pix.green) ||
						chan_far(w.blue, r.pix.blue))
					marks[i] = 1'b0;
			end
			if (r.last) begin
				rep.found = 1'b0;
				rep.index = '0;
				for (i = n - 1; i >= 0; i--) begin
					if (marks[i]) begin
						rep.found = 1'b1;
						rep.index = IDX_W'(i);
					end
				end
				reports_due.push_back(rep);
				marks = '1;
			end
		end
	endtask

	task automatic queue_req(input logic op, input int tile, input int pos, input rgb_t pix,
			input logic last);
		pixel_req_t r;
		r.opcode = op;
		r.tile   = IDX_W'(tile);
		r.pos    = POS_W'(pos);
		r.pix    = pix;
		r.last   = last;
		if (op == OP_LOAD) begin
			plan_img[tile][pos]    = pix;
			plan_loaded[tile][pos] = 1'b1;
		end
		pending_reqs.push_back(r);
		item_count++;
	endtask

	// Queues one candidate, usually close to a random entry in use but sometimes random, with stray loads mixed in.
	task automatic queue_candidate(input int order[$], input bit close_last);
		int   n_eff;
		int   target;
		int   k;
		bit   noisy;
		rgb_t pix;
		n_eff  = tiles_searched();
		target = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : 0;
		noisy  = (n_eff == 0) || ($urandom_range(0, 7) == 0);
		for (k = 0; k < order.size(); k++) begin
			if ($urandom_range(0, 15) == 0)
				queue_req(OP_LOAD, $urandom_range(0, 63), $urandom_range(0, 63), rand_rgb(),
					1'($urandom_range(0, 1)));
			pix = noisy ? rand_rgb() :
				near_pixel(plan_img[target][order[k]], int'(tol_reg), $urandom_range(0, 19) == 0);
			queue_req(OP_CANDIDATE, $urandom_range(0, 63), order[k], pix,
				close_last && (k == order.size() - 1));
		end
	endtask

	task automatic settle();
		@(negedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || reports_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_TOLERANCE)
			tol_reg = val[TOL_W-1:0];
		else
			tiles_reg = val[TILES_W-1:0];
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				apply_request(on_bus);
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >=
						((idle_mode == IDLE_SEND) ? 51 : (idle_mode == IDLE_BOTH) ? 22 : 0)) begin
					on_bus = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {4'b0, on_bus.pix.blue, on_bus.pix.green, on_bus.pix.red,
						on_bus.pos, on_bus.tile};
					s_tuser  <= on_bus.opcode;
					s_tlast  <= on_bus.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		match_report_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (reports_due.size() == 0) begin
					report_mismatch("match report with no request pending");
				end else begin
					want = reports_due.pop_front();
					if (m_tuser !== want.found)
						report_mismatch($sformatf("match_found got %b want %b", m_tuser, want.found));
					if (m_tdata !== {{(OUT_DATA_W - IDX_W){1'b0}}, want.index})
						report_mismatch($sformatf("match_index got %0d want %0d", m_tdata,
							want.index));
				end
			end
			m_tready <= $urandom_range(0, 99) >=
				((idle_mode == IDLE_RECV) ? 51 : (idle_mode == IDLE_BOTH) ? 22 : 0);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int phase;
		int n_eff;
		int cands;
		int c;
		int i;
		bit full;
		int spots[$];
		int order[$];

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// An empty dictionary never matches, and a load ignores its last mark.
		queue_req(OP_CANDIDATE, 63, 63, 24'hFFFFFF, 1'b1);
		queue_req(OP_LOAD, 0, 0, 24'h000000, 1'b1);
		queue_req(OP_LOAD, 1, 0, 24'hFFFFFF, 1'b0);
		queue_req(OP_LOAD, 2, 0, 24'h0A141E, 1'b0);
		queue_req(OP_LOAD, 63, 63, 24'hFF00FF, 1'b0);
		queue_req(OP_LOAD, 0, 63, 24'h020202, 1'b0);
		queue_req(OP_LOAD, 1, 63, 24'hFDFDFD, 1'b0);
		queue_req(OP_LOAD, 2, 63, 24'h0A141E, 1'b0);
		settle();
		write_reg(REG_TILES, 3);
		queue_req(OP_CANDIDATE, 0, 0, 24'h020202, 1'b1);
		queue_req(OP_CANDIDATE, 0, 0, 24'hFDFFFE, 1'b1);
		queue_req(OP_CANDIDATE, 0, 0, 24'h0C111E, 1'b1);
		queue_req(OP_CANDIDATE, 0, 0, 24'h09151F, 1'b0);
		queue_req(OP_CANDIDATE, 0, 63, 24'h0C121C, 1'b1);
		settle();
		write_reg(REG_TOLERANCE, 255);
		queue_req(OP_CANDIDATE, 0, 63, 24'h808080, 1'b1);
		settle();
		write_reg(REG_TOLERANCE, 0);
		queue_req(OP_CANDIDATE, 0, 0, 24'h0A141E, 1'b1);
		queue_req(OP_CANDIDATE, 0, 0, 24'h0A141F, 1'b1);

		phase = 0;
		while (item_count < ITEM_TARGET) begin
			settle();
			idle_mode = idle_mode_t'(phase % 4);
			case (phase)
				0: begin
					write_reg(REG_TOLERANCE, 0);
					write_reg(REG_TILES, 64);
				end
				1: begin
					write_reg(REG_TOLERANCE, 255);
					write_reg(REG_TILES, 127);
				end
				2: write_reg(REG_TILES, 0);
				default: begin
					if ($urandom_range(0, 2) != 0) begin
						case ($urandom_range(0, 3))
							0: write_reg(REG_TOLERANCE, 0);
							1: write_reg(REG_TOLERANCE, 255);
							2: write_reg(REG_TOLERANCE, $urandom_range(0, 6));
							default: write_reg(REG_TOLERANCE, $urandom_range(0, 255));
						endcase
					end
					case ($urandom_range(0, 7))
						0: write_reg(REG_TILES, $urandom_range(64, 127));
						1, 2: write_reg(REG_TILES, $urandom_range(9, 64));
						3: write_reg(REG_TILES, 0);
						default: write_reg(REG_TILES, $urandom_range(1, 8));
					endcase
				end
			endcase

			n_eff = tiles_searched();
			full  = (n_eff <= 2) && ($urandom_range(0, 2) == 0);
			spots.delete();
			if (full) begin
				for (i = 0; i < TILE_PIXELS; i++)
					spots.push_back(i);
			end else begin
				repeat ($urandom_range(1, (n_eff > 16) ? 2 : 5))
					spots.push_back($urandom_range(0, TILE_PIXELS - 1));
			end

			// Every entry in use gets the searched positions loaded, some as copies of
			// the entry below so that several entries can match at once.
			for (i = 0; i < n_eff; i++) begin
				foreach (spots[j]) begin
					if (!plan_loaded[i][spots[j]])
						queue_req(OP_LOAD, i, spots[j],
							(i > 0 && plan_loaded[i-1][spots[j]] && $urandom_range(0, 3) == 0) ?
								plan_img[i-1][spots[j]] : rand_rgb(),
							1'($urandom_range(0, 1)));
				end
			end

			cands = full ? 2 : $urandom_range(4, 10);
			for (c = 0; c < cands; c++) begin
				order = spots;
				order.shuffle();
				while (!full && order.size() > 1 && $urandom_range(0, 3) == 0)
					order.delete(order.size() - 1);
				if ($urandom_range(0, 3) == 0)
					order.push_back(order[0]);
				queue_candidate(order, !(c == cands - 1 && $urandom_range(0, 4) == 0));
			end
			phase++;
		end

		settle();
		if (err_count == 0 && reports_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
